// ===== design/spfa_pkg.sv =====
// spfa_pkg: shared types, codes and defaults of the spfa negative cycle detector
// no dependencies; imported by spfa_work_queue, spfa_negative_cycle_detect_unit and the bench
`timescale 1ns / 1ps
`default_nettype none

package spfa_pkg;

    // default sizes
    localparam int MAX_NODES_DEF   = 2048;
    localparam int MAX_EDGES_DEF   = 8192;
    localparam int WEIGHT_BITS_DEF = 16;

    // fixed field widths
    localparam int NODE_FIELD_W   = 11;
    localparam int WEIGHT_FIELD_W = 16;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 11;

    // infinity distance at run start
    localparam logic [31:0] DIST_INF = 32'h3f3f3f3f;

    // item kinds
    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_ADD   = 2'd1;
    localparam logic [1:0] KIND_RUN   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_NODE_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIRROR     = 2'd1;

    typedef struct packed {
        logic [1:0]                       kind;
        logic [NODE_FIELD_W-1:0]          from_node;
        logic [NODE_FIELD_W-1:0]          to_node;
        logic signed [WEIGHT_FIELD_W-1:0] weight;
    } in_item_t;

    typedef struct packed {
        logic negative_cycle;
        logic edges_dropped;
    } out_item_t;

    // work queue control
    typedef struct packed {
        logic init;
        logic push;
        logic pop;
    } q_ctrl_t;

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_ADD,
        ST_MIR,
        ST_INIT,
        ST_POP,
        ST_NODE,
        ST_EDGE0,
        ST_ECHK,
        ST_ERD,
        ST_RELAX,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ===== design/spfa_work_queue.sv =====
// spfa_work_queue: circular node queue in a memory with registered read
// depends on spfa_pkg (q_ctrl_t)
`timescale 1ns / 1ps
`default_nettype none

module spfa_work_queue #(
    parameter int MAX_NODES = spfa_pkg::MAX_NODES_DEF,
    parameter int NODE_W    = $clog2(MAX_NODES),
    parameter int CNT_W     = $clog2(MAX_NODES + 1)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire spfa_pkg::q_ctrl_t ctrl,
    input  wire logic [NODE_W-1:0] push_node,
    output logic [NODE_W-1:0]     pop_node,
    output logic [CNT_W-1:0]      len
);
    import spfa_pkg::*;

    localparam logic [NODE_W-1:0] LAST = NODE_W'(MAX_NODES - 1);

    logic [NODE_W-1:0] mem [MAX_NODES];
    logic [NODE_W-1:0] head_reg, head_next;
    logic [NODE_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0]  len_reg, len_next;
    logic [NODE_W-1:0] rdata_reg;

    // pointer and count update
    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        len_next  = len_reg;
        if (ctrl.init)
        begin
            head_next = '0;
            tail_next = '0;
            len_next  = '0;
        end
        else
        begin
            if (ctrl.pop)
            begin
                head_next = (head_reg == LAST) ? '0 : head_reg + 1'b1;
            end
            if (ctrl.push)
            begin
                tail_next = (tail_reg == LAST) ? '0 : tail_reg + 1'b1;
            end
            len_next = len_reg + CNT_W'(ctrl.push) - CNT_W'(ctrl.pop);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            len_reg  <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            len_reg  <= len_next;
        end
    end

    // storage, read data valid the cycle after pop
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[tail_reg] <= push_node;
        end
        rdata_reg <= mem[head_reg];
    end

    assign pop_node = rdata_reg;
    assign len      = len_reg;

endmodule

`default_nettype wire

// ===== design/spfa_negative_cycle_detect_unit.sv =====
// spfa_negative_cycle_detect_unit: top level, edge store, sequencer and node memories
// depends on spfa_pkg and spfa_work_queue
`timescale 1ns / 1ps
`default_nettype none

// Loads a weighted directed graph one edge per item and, on a run item, performs a
// queue-based Bellman-Ford (SPFA) from node 1, giving one result item that says whether a
// negative cycle is reachable and whether any edge was dropped since the last clear.
// Clear and add items give no result. The block handles one item at a time and holds
// in_stall high until it is done. After reset and after each clear item, a clearing pass
// runs over the per-node edge list heads. An add item passes the add state, plus the
// mirror state when the edge is also stored reversed. A run item resets the distance, hop
// and queue mark memories, then walks pop, node and first-edge states per dequeued node and
// check, read and relax states per edge walked, reading the edge and node memories through
// registered reads; on an empty queue or a found negative cycle it posts the answer, which
// then waits in an output register until taken.
module spfa_negative_cycle_detect_unit #(
    parameter int MAX_NODES   = spfa_pkg::MAX_NODES_DEF,
    parameter int MAX_EDGES   = spfa_pkg::MAX_EDGES_DEF,
    parameter int WEIGHT_BITS = spfa_pkg::WEIGHT_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire spfa_pkg::in_item_t                  in_data,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output spfa_pkg::out_item_t                      out_data,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [spfa_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [spfa_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import spfa_pkg::*;

    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int CNT_W  = $clog2(MAX_NODES + 1);
    localparam int EDGE_W = $clog2(MAX_EDGES);
    localparam int LINK_W = $clog2(MAX_EDGES + 1);
    localparam int DIST_W = (WEIGHT_BITS + NODE_W + 2 > 32) ? WEIGHT_BITS + NODE_W + 2 : 32;

    localparam logic [LINK_W-1:0] EMPTY_LINK = LINK_W'(MAX_EDGES);
    localparam logic [NODE_W-1:0] LAST_NODE  = NODE_W'(MAX_NODES - 1);
    localparam logic [NODE_W-1:0] START_NODE = NODE_W'(1);
    localparam logic signed [DIST_W-1:0] INF = DIST_W'(DIST_INF);

    // state and configuration
    state_t                  state_reg, state_next;
    logic [CFG_DATA_W-1:0]   node_count_reg;
    logic                    mirror_reg;
    logic [NODE_W-1:0]       sweep_reg;

    // add edge item
    logic [NODE_W-1:0]       src_reg, dst_reg;
    logic [WEIGHT_BITS-1:0]  w_reg;
    logic [LINK_W-1:0]       edge_total_reg;
    logic                    overflow_reg;
    logic                    fwd_ok_reg;

    // run working registers
    logic [NODE_W-1:0]       a_reg, b_reg;
    logic [LINK_W-1:0]       e_reg;
    logic signed [DIST_W-1:0] da_reg, nd_reg;
    logic [NODE_W-1:0]       ha_reg;
    logic                    b_ok_reg;

    // result
    logic                    result_reg;
    logic                    out_valid_reg;
    out_item_t               out_data_reg;

    // memories
    logic [LINK_W-1:0]        nfe_mem [MAX_NODES];
    logic [NODE_W-1:0]        et_mem  [MAX_EDGES];
    logic [WEIGHT_BITS-1:0]   ew_mem  [MAX_EDGES];
    logic [LINK_W-1:0]        en_mem  [MAX_EDGES];
    logic signed [DIST_W-1:0] dist_mem [MAX_NODES];
    logic [NODE_W-1:0]        hop_mem  [MAX_NODES];
    logic                     mark_mem [MAX_NODES];

    logic [LINK_W-1:0]        nfe_rdata_reg;
    logic [NODE_W-1:0]        et_rdata_reg;
    logic [WEIGHT_BITS-1:0]   ew_rdata_reg;
    logic [LINK_W-1:0]        en_rdata_reg;
    logic signed [DIST_W-1:0] dist_rdata_reg;
    logic [NODE_W-1:0]        hop_rdata_reg;
    logic                     mark_rdata_reg;

    // memory control
    logic                     nfe_we;
    logic [NODE_W-1:0]        nfe_waddr, nfe_raddr;
    logic [LINK_W-1:0]        nfe_wdata;
    logic                     edge_we;
    logic [LINK_W-1:0]        edge_link;
    logic                     dist_we, hop_we, mark_we;
    logic [NODE_W-1:0]        dist_waddr, dist_raddr, hop_waddr, mark_waddr;
    logic signed [DIST_W-1:0] dist_wdata;
    logic [NODE_W-1:0]        hop_wdata;
    logic                     mark_wdata;

    // queue
    q_ctrl_t                  q_ctrl;
    logic [NODE_W-1:0]        q_push_node;
    logic [NODE_W-1:0]        q_pop_node;
    logic [CNT_W-1:0]         q_len;

    // decoded item and run terms
    logic                     in_accept;
    logic [31:0]              w_raw;
    logic [WEIGHT_BITS-1:0]   in_w;
    logic                     ends_ok;
    logic [31:0]              n_wide;
    logic [NODE_W-1:0]        n_eff;
    logic                     slot_free;
    logic                     edge_end;
    logic                     relax;
    logic [NODE_W:0]          hop_new;
    logic                     hop_hit;
    logic                     can_push;
    logic                     out_free;
    logic                     mirror_need;

    assign in_accept = in_valid && !in_stall;
    assign w_raw     = {16'b0, in_data.weight};
    assign in_w      = w_raw[WEIGHT_BITS-1:0];
    assign ends_ok   = (32'(in_data.from_node) < MAX_NODES) && (32'(in_data.to_node) < MAX_NODES);
    assign n_wide    = 32'(node_count_reg);
    assign n_eff     = (n_wide == 32'd0) ? START_NODE :
                       (n_wide >= MAX_NODES) ? LAST_NODE : NODE_W'(n_wide);
    assign slot_free = edge_total_reg < EMPTY_LINK;
    assign edge_end  = e_reg >= EMPTY_LINK;
    assign relax     = b_ok_reg && (nd_reg < dist_rdata_reg);
    assign hop_new   = {1'b0, ha_reg} + 1'b1;
    assign hop_hit   = hop_new >= {1'b0, n_eff};
    assign can_push  = !mark_rdata_reg && (q_len < CNT_W'(MAX_NODES));
    assign out_free  = !out_valid_reg || !out_stall;
    assign mirror_need = mirror_reg && !w_reg[WEIGHT_BITS-1];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLR:
            begin
                if (sweep_reg == LAST_NODE)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (in_data.kind == KIND_CLEAR)
                    begin
                        state_next = ST_CLR;
                    end
                    else if (in_data.kind == KIND_ADD && ends_ok)
                    begin
                        state_next = ST_ADD;
                    end
                    else if (in_data.kind == KIND_RUN)
                    begin
                        state_next = ST_INIT;
                    end
                end
            end
            ST_ADD:   state_next = mirror_need ? ST_MIR : ST_IDLE;
            ST_MIR:   state_next = ST_IDLE;
            ST_INIT:
            begin
                if (sweep_reg == LAST_NODE)
                begin
                    state_next = ST_POP;
                end
            end
            ST_POP:   state_next = (q_len == '0) ? ST_DONE : ST_NODE;
            ST_NODE:  state_next = ST_EDGE0;
            ST_EDGE0: state_next = ST_ECHK;
            ST_ECHK:  state_next = edge_end ? ST_POP : ST_ERD;
            ST_ERD:   state_next = ST_RELAX;
            ST_RELAX: state_next = (relax && hop_hit) ? ST_DONE : ST_ECHK;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // memory and queue control
    always_comb
    begin
        nfe_we      = 1'b0;
        nfe_waddr   = src_reg;
        nfe_wdata   = edge_total_reg;
        nfe_raddr   = a_reg;
        edge_we     = 1'b0;
        edge_link   = nfe_rdata_reg;
        dist_we     = 1'b0;
        dist_waddr  = b_reg;
        dist_wdata  = nd_reg;
        dist_raddr  = a_reg;
        hop_we      = 1'b0;
        hop_waddr   = b_reg;
        hop_wdata   = hop_new[NODE_W-1:0];
        mark_we     = 1'b0;
        mark_waddr  = b_reg;
        mark_wdata  = 1'b1;
        q_ctrl      = '0;
        q_push_node = b_reg;
        case (state_reg)
            ST_CLR:
            begin
                nfe_we    = 1'b1;
                nfe_waddr = sweep_reg;
                nfe_wdata = EMPTY_LINK;
            end
            ST_IDLE:
            begin
                nfe_raddr   = NODE_W'(in_data.from_node);
                q_ctrl.init = in_accept && in_data.kind == KIND_RUN;
            end
            ST_ADD:
            begin
                nfe_raddr = dst_reg;
                edge_we   = slot_free;
                nfe_we    = slot_free;
            end
            ST_MIR:
            begin
                if (dst_reg == src_reg && fwd_ok_reg)
                begin
                    edge_link = edge_total_reg - 1'b1;
                end
                edge_we   = slot_free;
                nfe_we    = slot_free;
                nfe_waddr = dst_reg;
            end
            ST_INIT:
            begin
                dist_we     = 1'b1;
                dist_waddr  = sweep_reg;
                dist_wdata  = (sweep_reg == START_NODE) ? '0 : INF;
                hop_we      = 1'b1;
                hop_waddr   = sweep_reg;
                hop_wdata   = '0;
                mark_we     = 1'b1;
                mark_waddr  = sweep_reg;
                mark_wdata  = (sweep_reg == START_NODE);
                q_ctrl.push = (sweep_reg == LAST_NODE);
                q_push_node = START_NODE;
            end
            ST_POP:
            begin
                q_ctrl.pop = (q_len != '0);
            end
            ST_NODE:
            begin
                nfe_raddr  = q_pop_node;
                dist_raddr = q_pop_node;
                mark_we    = 1'b1;
                mark_waddr = q_pop_node;
                mark_wdata = 1'b0;
            end
            ST_ERD:
            begin
                dist_raddr = et_rdata_reg;
            end
            ST_RELAX:
            begin
                dist_we     = relax;
                hop_we      = relax;
                q_ctrl.push = relax && !hop_hit && can_push;
                mark_we     = relax && !hop_hit && can_push;
            end
            default:
            begin
            end
        endcase
    end

    // node memories
    always_ff @(posedge clk)
    begin
        if (nfe_we)
        begin
            nfe_mem[nfe_waddr] <= nfe_wdata;
        end
        nfe_rdata_reg <= nfe_mem[nfe_raddr];
        if (dist_we)
        begin
            dist_mem[dist_waddr] <= dist_wdata;
        end
        dist_rdata_reg <= dist_mem[dist_raddr];
        if (hop_we)
        begin
            hop_mem[hop_waddr] <= hop_wdata;
        end
        hop_rdata_reg <= hop_mem[nfe_raddr];
        if (mark_we)
        begin
            mark_mem[mark_waddr] <= mark_wdata;
        end
        mark_rdata_reg <= mark_mem[dist_raddr];
    end

    // edge store, written at the fill count, read at the walk pointer
    always_ff @(posedge clk)
    begin
        if (edge_we)
        begin
            et_mem[edge_total_reg[EDGE_W-1:0]] <= (state_reg == ST_MIR) ? src_reg : dst_reg;
            ew_mem[edge_total_reg[EDGE_W-1:0]] <= w_reg;
            en_mem[edge_total_reg[EDGE_W-1:0]] <= edge_link;
        end
        et_rdata_reg <= et_mem[e_reg[EDGE_W-1:0]];
        ew_rdata_reg <= ew_mem[e_reg[EDGE_W-1:0]];
        en_rdata_reg <= en_mem[e_reg[EDGE_W-1:0]];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLR;
            sweep_reg      <= '0;
            edge_total_reg <= '0;
            overflow_reg   <= 1'b0;
            node_count_reg <= CFG_DATA_W'(1);
            mirror_reg     <= 1'b1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // configuration writes
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_NODE_COUNT)
                begin
                    node_count_reg <= cfg_data;
                end
                else if (cfg_index == CFG_MIRROR)
                begin
                    mirror_reg <= cfg_data[0];
                end
            end

            // sweep counter for clearing and run init
            if (state_reg == ST_CLR || state_reg == ST_INIT)
            begin
                sweep_reg <= (sweep_reg == LAST_NODE) ? '0 : sweep_reg + 1'b1;
            end

            // edge fill count and drop flag
            if (state_reg == ST_IDLE && in_accept && in_data.kind == KIND_CLEAR)
            begin
                edge_total_reg <= '0;
                overflow_reg   <= 1'b0;
            end
            else if (state_reg == ST_ADD || (state_reg == ST_MIR))
            begin
                if (slot_free)
                begin
                    edge_total_reg <= edge_total_reg + 1'b1;
                end
                else
                begin
                    overflow_reg <= 1'b1;
                end
            end

            // result item
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                src_reg <= NODE_W'(in_data.from_node);
                dst_reg <= NODE_W'(in_data.to_node);
                w_reg   <= in_w;
            end
            ST_ADD:
            begin
                fwd_ok_reg <= slot_free;
            end
            ST_POP:
            begin
                result_reg <= 1'b0;
            end
            ST_NODE:
            begin
                a_reg <= q_pop_node;
            end
            ST_EDGE0:
            begin
                e_reg  <= nfe_rdata_reg;
                da_reg <= dist_rdata_reg;
                ha_reg <= hop_rdata_reg;
            end
            ST_ERD:
            begin
                b_reg    <= et_rdata_reg;
                nd_reg   <= da_reg + DIST_W'($signed(ew_rdata_reg));
                b_ok_reg <= (et_rdata_reg != '0) && (et_rdata_reg <= n_eff);
                e_reg    <= en_rdata_reg;
            end
            ST_RELAX:
            begin
                // a self loop updates the node being scanned
                if (relax && b_reg == a_reg)
                begin
                    da_reg <= nd_reg;
                    ha_reg <= hop_new[NODE_W-1:0];
                end
                if (relax && hop_hit)
                begin
                    result_reg <= 1'b1;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_data_reg.negative_cycle <= result_reg;
                    out_data_reg.edges_dropped  <= overflow_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    spfa_work_queue #(
        .MAX_NODES (MAX_NODES),
        .NODE_W    (NODE_W),
        .CNT_W     (CNT_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (q_ctrl),
        .push_node (q_push_node),
        .pop_node  (q_pop_node),
        .len       (q_len)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

// ===== tb/spfa_negative_cycle_detect_unit_tb.sv =====
// spfa_negative_cycle_detect_unit_tb: self-checking bench for the spfa negative cycle detector
// drives clear, add, run and spare-kind items plus register writes, predicts each run answer itself
// depends on spfa_pkg and spfa_negative_cycle_detect_unit
`timescale 1ns / 1ps

module spfa_negative_cycle_detect_unit_tb;
    import spfa_pkg::*;

    localparam int NODES       = MAX_NODES_DEF;
    localparam int EDGES       = MAX_EDGES_DEF;
    localparam int SETTLE      = NODES + 64;
    localparam int CYCLE_LIMIT = 6000000;

    // kind code with no function
    localparam logic [1:0] KIND_SPARE = 2'd3;

    typedef struct {
        bit                      is_cfg;
        logic [CFG_INDEX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0]   reg_value;
        in_item_t                item;
        bit                      known;
        bit                      known_cycle;
        bit                      known_dropped;
    } stim_row_t;

    typedef struct {
        bit known;
        bit known_cycle;
        bit known_dropped;
    } typed_answer_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // predictor state: graph store, registers, run scratch
    int          graph_target [0:EDGES-1];
    int          graph_weight [0:EDGES-1];
    int          graph_link   [0:EDGES-1];
    int          graph_head   [0:NODES-1];
    int          graph_total;
    bit          graph_overflow;
    int          active_nodes;
    bit          mirror_on;
    longint      path_len   [0:NODES-1];
    int          path_hops  [0:NODES-1];
    bit          in_fifo    [0:NODES-1];
    int          node_fifo  [0:NODES-1];

    out_item_t     answer_q[$];
    typed_answer_t typed_q[$];

    int  errors;
    int  cycles;
    int  items_sent;
    int  runs_checked;
    int  cycles_found;
    int  dropped_seen;
    int  tx_idle_pct;
    int  rx_stall_pct;

    stim_row_t rows[$];

    spfa_negative_cycle_detect_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // graph store predictor
    function automatic void wipe_graph();
        for (int i = 0; i < NODES; i++)
        begin
            graph_head[i] = EDGES;
        end
        graph_total    = 0;
        graph_overflow = 1'b0;
    endfunction

    function automatic void link_arc(int src, int dst, int w);
        if (graph_total >= EDGES)
        begin
            graph_overflow = 1'b1;
            return;
        end
        graph_target[graph_total] = dst;
        graph_weight[graph_total] = w;
        graph_link[graph_total]   = graph_head[src];
        graph_head[src]           = graph_total;
        graph_total++;
    endfunction

    // queue-based bellman-ford from node 1, 1 when a negative cycle is reached
    function automatic bit find_negative_cycle();
        int n;
        int head;
        int tail;
        int len;
        int a;
        int b;
        int e;
        longint nd;
        n = active_nodes;
        if (n == 0)
            n = 1;
        if (n >= NODES)
            n = NODES - 1;
        for (int i = 0; i < NODES; i++)
        begin
            path_len[i]  = longint'(DIST_INF);
            path_hops[i] = 0;
            in_fifo[i]   = 1'b0;
        end
        path_len[1]  = 0;
        node_fifo[0] = 1;
        head = 0;
        tail = 1;
        len  = 1;
        in_fifo[1] = 1'b1;
        while (len > 0)
        begin
            a    = node_fifo[head];
            head = (head + 1) % NODES;
            len--;
            in_fifo[a] = 1'b0;
            e = graph_head[a];
            while (e < EDGES)
            begin
                b  = graph_target[e];
                nd = path_len[a] + graph_weight[e];
                if (b != 0 && b <= n && nd < path_len[b])
                begin
                    path_len[b]  = nd;
                    path_hops[b] = path_hops[a] + 1;
                    if (path_hops[b] >= n)
                        return 1'b1;
                    if (!in_fifo[b] && len < NODES)
                    begin
                        node_fifo[tail] = b;
                        tail = (tail + 1) % NODES;
                        len++;
                        in_fifo[b] = 1'b1;
                    end
                end
                e = graph_link[e];
            end
        end
        return 1'b0;
    endfunction

    function automatic void predict_item(in_item_t it);
        out_item_t res;
        int w;
        case (it.kind)
            KIND_CLEAR: wipe_graph();
            KIND_ADD:
            begin
                w = int'(it.weight);
                link_arc(int'(it.from_node), int'(it.to_node), w);
                if (mirror_on && w >= 0)
                    link_arc(int'(it.to_node), int'(it.from_node), w);
            end
            KIND_RUN:
            begin
                res.negative_cycle = find_negative_cycle();
                res.edges_dropped  = graph_overflow;
                answer_q.insert(answer_q.size(), res);
            end
            default: ;
        endcase
    endfunction

    // check results, then predict the accepted item
    always @(posedge clk)
    begin
        typed_answer_t t;
        out_item_t     x;
        if (rst_n && out_valid && !out_stall)
        begin
            if (answer_q.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing expected, actual %b/%b", $time,
                         out_data.negative_cycle, out_data.edges_dropped);
            end
            else
            begin
                x = answer_q.pop_front();
                t = typed_q.pop_front();
                runs_checked++;
                if (out_data.negative_cycle)
                    cycles_found++;
                if (out_data.edges_dropped)
                    dropped_seen++;
                if (out_data.negative_cycle !== x.negative_cycle)
                begin
                    errors++;
                    $display("%0t: negative_cycle expected %b actual %b", $time,
                             x.negative_cycle, out_data.negative_cycle);
                end
                if (out_data.edges_dropped !== x.edges_dropped)
                begin
                    errors++;
                    $display("%0t: edges_dropped expected %b actual %b", $time,
                             x.edges_dropped, out_data.edges_dropped);
                end
                if (t.known && (out_data.negative_cycle !== t.known_cycle
                                || out_data.edges_dropped !== t.known_dropped))
                begin
                    errors++;
                    $display("%0t: directed answer expected %b/%b actual %b/%b", $time,
                             t.known_cycle, t.known_dropped,
                             out_data.negative_cycle, out_data.edges_dropped);
                end
            end
        end
        if (rst_n && in_valid && !in_stall)
            predict_item(in_data);
    end

    // receiver stall
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("spfa_negative_cycle_detect_unit_tb NOT OK");
            $finish;
        end
    end

    // send one item, with random idle cycles before it
    task automatic send_item(in_item_t it, bit known, bit kc, bit kd);
        typed_answer_t t;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        if (it.kind == KIND_RUN)
        begin
            t.known         = known;
            t.known_cycle   = kc;
            t.known_dropped = kd;
            typed_q.insert(typed_q.size(), t);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    // wait until every answer is in and the block has gone quiet
    task automatic drain();
        in_valid <= 1'b0;
        while (answer_q.size() != 0 || typed_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // one register write, then the write channel is left idle before the task returns
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_NODE_COUNT)
            active_nodes = int'(val);
        else if (idx == CFG_MIRROR)
            mirror_on = val[0];
        @(posedge clk);
    endtask

    function automatic in_item_t make_item(logic [1:0] k, int s, int d, int w);
        in_item_t it;
        it.kind      = k;
        it.from_node = s[NODE_FIELD_W-1:0];
        it.to_node   = d[NODE_FIELD_W-1:0];
        it.weight    = w[WEIGHT_FIELD_W-1:0];
        return it;
    endfunction

    function automatic void add_row(bit c, logic [CFG_INDEX_W-1:0] idx, int val,
                                    in_item_t it, bit known, bit kc, bit kd);
        stim_row_t r;
        r.is_cfg        = c;
        r.reg_index     = idx;
        r.reg_value     = val[CFG_DATA_W-1:0];
        r.item          = it;
        r.known         = known;
        r.known_cycle   = kc;
        r.known_dropped = kd;
        rows.insert(rows.size(), r);
    endfunction

    function automatic int pick_node(int n);
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(0, NODES - 1);
        return $urandom_range(0, (n + 1 > NODES - 1) ? NODES - 1 : n + 1);
    endfunction

    function automatic int pick_weight();
        if ($urandom_range(0, 9) == 0)
            return int'($signed(16'($urandom)));
        return $urandom_range(0, 25) - 5;
    endfunction

    // one random graph: node count write, optional mirror write, clear, edges, one or more runs
    task automatic random_graph();
        int n;
        int r;
        int arcs;
        in_item_t z;
        z = make_item(KIND_RUN, 0, 0, 0);
        drain();
        r = $urandom_range(0, 39);
        n = (r == 0) ? 0 : (r == 1) ? 1 : (r == 2) ? NODES - 1 : $urandom_range(2, 10);
        write_reg(CFG_NODE_COUNT, n[CFG_DATA_W-1:0]);
        if ($urandom_range(0, 2) == 0)
            write_reg(CFG_MIRROR, CFG_DATA_W'($urandom_range(0, 1)));
        if (n == NODES - 1)
            n = 10;
        send_item(make_item(KIND_CLEAR, $urandom, $urandom, $urandom), 0, 0, 0);
        arcs = $urandom_range(1, 3 * (n + 1));
        for (int i = 0; i < arcs; i++)
        begin
            if ($urandom_range(0, 29) == 0)
                send_item(make_item(KIND_SPARE, $urandom, $urandom, $urandom), 0, 0, 0);
            send_item(make_item(KIND_ADD, pick_node(n), pick_node(n), pick_weight()), 0, 0, 0);
            if ($urandom_range(0, 24) == 0)
                send_item(z, 0, 0, 0);
        end
        send_item(make_item(KIND_RUN, $urandom, $urandom, $urandom), 0, 0, 0);
    endtask

    initial
    begin
        in_item_t nul;
        nul = make_item(KIND_CLEAR, 0, 0, 0);
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        out_stall    = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        errors       = 0;
        cycles       = 0;
        items_sent   = 0;
        runs_checked = 0;
        cycles_found = 0;
        dropped_seen = 0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        active_nodes = 1;
        mirror_on    = 1'b1;
        wipe_graph();

        // directed rows, starting from reset: one node, mirroring on
        add_row(0, 0, 0, make_item(KIND_RUN, 0, 0, 0), 1, 0, 0);
        add_row(0, 0, 0, make_item(KIND_ADD, 1, 1, -1), 0, 0, 0);
        add_row(0, 0, 0, make_item(KIND_RUN, 0, 0, 0), 1, 1, 0);
        add_row(0, 0, 0, make_item(KIND_CLEAR, 2047, 2047, -1), 0, 0, 0);
        add_row(0, 0, 0, make_item(KIND_ADD, 1, 2, 32767), 0, 0, 0);
        add_row(0, 0, 0, make_item(KIND_ADD, 2047, 2047, -32768), 0, 0, 0);
        add_row(0, 0, 0, make_item(KIND_ADD, 1, 0, -32768), 0, 0, 0);
        add_row(0, 0, 0, make_item(KIND_SPARE, 2047, 2047, -1), 0, 0, 0);
        add_row(0, 0, 0, make_item(KIND_RUN, 2047, 2047, -1), 1, 0, 0);
        add_row(1, CFG_NODE_COUNT, 2, nul, 0, 0, 0);
        add_row(0, 0, 0, make_item(KIND_RUN, 0, 0, 0), 1, 0, 0);
        add_row(0, 0, 0, make_item(KIND_ADD, 2, 1, -32768), 0, 0, 0);
        add_row(0, 0, 0, make_item(KIND_RUN, 0, 0, 0), 1, 1, 0);
        add_row(1, CFG_MIRROR, 0, nul, 0, 0, 0);
        add_row(0, 0, 0, make_item(KIND_CLEAR, 0, 0, 0), 0, 0, 0);
        add_row(0, 0, 0, make_item(KIND_ADD, 1, 2, 0), 0, 0, 0);
        add_row(0, 0, 0, make_item(KIND_ADD, 2, 1, 0), 0, 0, 0);
        add_row(0, 0, 0, make_item(KIND_RUN, 0, 0, 0), 1, 0, 0);
        add_row(1, CFG_NODE_COUNT, 2047, nul, 0, 0, 0);
        add_row(0, 0, 0, make_item(KIND_ADD, 2, 2, -1), 0, 0, 0);
        add_row(0, 0, 0, make_item(KIND_RUN, 0, 0, 0), 0, 0, 0);
        add_row(1, CFG_NODE_COUNT, 0, nul, 0, 0, 0);
        add_row(0, 0, 0, make_item(KIND_RUN, 0, 0, 0), 1, 0, 0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        foreach (rows[i])
        begin
            if (rows[i].is_cfg)
            begin
                drain();
                write_reg(rows[i].reg_index, rows[i].reg_value);
            end
            else
            begin
                send_item(rows[i].item, rows[i].known, rows[i].known_cycle,
                          rows[i].known_dropped);
            end
        end

        // random part in three idling phases
        for (int ph = 0; ph < 3; ph++)
        begin
            int goal;
            drain();
            tx_idle_pct  = (ph == 0) ? 18 : (ph == 1) ? 62 : 0;
            rx_stall_pct = (ph == 0) ? 62 : (ph == 1) ? 18 : 0;
            goal = items_sent + 500;
            while (items_sent < goal)
                random_graph();
        end

        drain();
        repeat (SETTLE) @(posedge clk);
        $display("sent %0d items, checked %0d run answers", items_sent, runs_checked);
        $display("negative cycles reported %0d, answers with dropped edges %0d",
                 cycles_found, dropped_seen);
        if (errors == 0 && answer_q.size() == 0)
            $display("spfa_negative_cycle_detect_unit_tb OK");
        else
            $display("spfa_negative_cycle_detect_unit_tb NOT OK");
        $finish;
    end

endmodule
